>>> rtl/hsf_pkg.sv
package hsf_pkg;

  // Model size and number format.
  localparam int STATES    = 16;
  localparam int SYMBOLS   = 16;
  localparam int PROB_BITS = 16;

  // Derived widths.
  localparam int IDX_W     = $clog2(STATES);
  localparam int SYM_W     = $clog2(SYMBOLS);
  localparam int TBL_MAX   = (STATES > SYMBOLS) ? STATES : SYMBOLS;
  localparam int ADDR_W    = $clog2(STATES * TBL_MAX);
  localparam int ACC_W     = 2 * PROB_BITS + IDX_W;
  localparam int U_W       = ACC_W + PROB_BITS;
  localparam int S_W       = U_W + IDX_W;
  localparam int SUM_SHIFT = 3 * PROB_BITS - 24;
  localparam int K_W       = $clog2(PROB_BITS);

  // Input opcodes.
  localparam logic [1:0] OP_LOAD_TRANS = 2'd0;
  localparam logic [1:0] OP_LOAD_EMIT  = 2'd1;
  localparam logic [1:0] OP_LOAD_INIT  = 2'd2;
  localparam logic [1:0] OP_OBSERVE    = 2'd3;

  // Classified command kinds passed from the front to the back.
  typedef enum logic [2:0] {
    CMD_LOAD_T,
    CMD_LOAD_E,
    CMD_LOAD_I,
    CMD_OBSERVE,
    CMD_DROP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [ADDR_W-1:0]     addr;
    logic [PROB_BITS-1:0]  prob;
    logic [SYM_W-1:0]      sym;
    logic                  sym_ok;
    logic                  start;
  } cmd_t;

endpackage

>>> rtl/hmm_scaled_forward.sv
// Scaled forward pass of a hidden Markov model, probabilities in unsigned Q0.16.
// Input channel (in_valid_i/in_ready_o): each item either loads one entry of the
// transition, emission or initial table, or observes one symbol. Loads at an
// out-of-range index are dropped. Loads cause no result item.
// Output channel (out_valid_o/out_ready_i): an observe item yields STATES result
// items in state order, each with the normalized alpha, the unscaled sum in
// Q0.24 and the zero-sum flag; last_o marks the final state.
// Processing: a load is written into its table by the back end. An observe item
// runs, per state, a multiply-accumulate over all predecessor states and then a
// multiply by the emission (a start item uses the initial value instead), then
// normalizes each state on one restoring divider that yields one quotient bit a
// cycle. Items are processed one at a time.
// A two-entry queue in front lets the block take items while the back end is
// busy. When the receiver stalls, the divider holds its finished value until
// the output register frees, so no result is lost.
// Reset empties the queue and the output and marks the alpha vector invalid, so it
// reads as zero; the tables hold no defined value until they are written.
module hmm_scaled_forward (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [5:0]  row_index_i,
  input  logic [7:0]  col_index_i,
  input  logic [15:0] prob_value_i,
  input  logic [7:0]  symbol_i,
  input  logic        seq_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  state_index_o,
  output logic [15:0] alpha_value_o,
  output logic [23:0] scale_sum_o,
  output logic        zero_sum_o,
  output logic        last_o
);
  import hsf_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  // Classification and queueing.
  hsf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .row_index_i  (row_index_i),
    .col_index_i  (col_index_i),
    .prob_value_i (prob_value_i),
    .symbol_i     (symbol_i),
    .seq_start_i  (seq_start_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  // Tables, forward recursion and normalization.
  hsf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .state_index_o (state_index_o),
    .alpha_value_o (alpha_value_o),
    .scale_sum_o   (scale_sum_o),
    .zero_sum_o    (zero_sum_o),
    .last_o        (last_o)
  );

endmodule

>>> rtl/hsf_front.sv
module hsf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     opcode_i,
  input  logic [5:0]     row_index_i,
  input  logic [7:0]     col_index_i,
  input  logic [15:0]    prob_value_i,
  input  logic [7:0]     symbol_i,
  input  logic           seq_start_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output hsf_pkg::cmd_t  cmd_o
);
  import hsf_pkg::*;

  cmd_t       cmd;
  logic       row_ok;
  logic       col_st_ok;
  logic       col_sym_ok;
  cmd_t       fifo_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  logic       pop;

  // Classify the incoming item and precompute its table address.
  assign row_ok     = int'(row_index_i) < STATES;
  assign col_st_ok  = int'(col_index_i) < STATES;
  assign col_sym_ok = int'(col_index_i) < SYMBOLS;

  always_comb begin
    cmd.addr   = '0;
    cmd.prob   = PROB_BITS'(prob_value_i);
    cmd.sym    = SYM_W'(symbol_i);
    cmd.sym_ok = int'(symbol_i) < SYMBOLS;
    cmd.start  = seq_start_i;
    cmd.kind   = CMD_DROP;
    case (opcode_i)
      OP_LOAD_TRANS: begin
        cmd.addr = ADDR_W'(row_index_i) * ADDR_W'(STATES) + ADDR_W'(col_index_i);
        if (row_ok && col_st_ok) cmd.kind = CMD_LOAD_T;
      end
      OP_LOAD_EMIT: begin
        cmd.addr = ADDR_W'(row_index_i) * ADDR_W'(SYMBOLS) + ADDR_W'(col_index_i);
        if (row_ok && col_sym_ok) cmd.kind = CMD_LOAD_E;
      end
      OP_LOAD_INIT: begin
        cmd.addr = ADDR_W'(row_index_i);
        if (row_ok) cmd.kind = CMD_LOAD_I;
      end
      OP_OBSERVE: begin
        cmd.kind = CMD_OBSERVE;
      end
      default: begin
        cmd.kind = CMD_DROP;
      end
    endcase
  end

  // Two-entry queue toward the back end.
  assign in_ready_o  = cnt_q != 2'd2;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

>>> rtl/hsf_back.sv
module hsf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  hsf_pkg::cmd_t  cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [5:0]     state_index_o,
  output logic [15:0]    alpha_value_o,
  output logic [23:0]    scale_sum_o,
  output logic           zero_sum_o,
  output logic           last_o
);
  import hsf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_UMUL,
    ST_STORE,
    ST_DRD,
    ST_DINIT,
    ST_DSTEP,
    ST_OUT
  } state_e;

  state_e                state_q;
  logic [IDX_W-1:0]      i_q;
  logic [IDX_W-1:0]      j_q;
  logic [K_W-1:0]        k_q;
  logic [SYM_W-1:0]      sym_q;
  logic                  sym_ok_q;
  logic                  start_q;
  logic [STATES-1:0]     alpha_vld_q;
  logic                  alpha_vr_q;
  logic                  s1_vld_q;
  logic                  s1_last_q;
  logic                  s2_vld_q;
  logic                  s2_last_q;
  logic [2*PROB_BITS-1:0] prod_q;
  logic [ACC_W-1:0]      acc_q;
  logic [U_W-1:0]        u_q;
  logic [S_W-1:0]        s_q;
  logic [S_W-1:0]        r_q;
  logic [PROB_BITS:0]    q_q;
  logic                  out_vld_q;
  logic [5:0]            out_idx_q;
  logic [15:0]           out_alpha_q;
  logic [23:0]           out_sum_q;
  logic                  out_zero_q;
  logic                  out_last_q;

  // Table memories with registered read data.
  logic [PROB_BITS-1:0]  trans_mem [STATES*STATES];
  logic [PROB_BITS-1:0]  emit_mem  [STATES*SYMBOLS];
  logic [PROB_BITS-1:0]  init_mem  [STATES];
  logic [PROB_BITS-1:0]  alpha_mem [STATES];
  logic [U_W-1:0]        u_mem     [STATES];
  logic [PROB_BITS-1:0]  trans_rd_q;
  logic [PROB_BITS-1:0]  emit_rd_q;
  logic [PROB_BITS-1:0]  init_rd_q;
  logic [PROB_BITS-1:0]  alpha_rd_q;
  logic [U_W-1:0]        u_rd_q;

  logic                  pop;
  logic                  t_we;
  logic                  e_we;
  logic                  i_we;
  logic [ADDR_W-1:0]     t_raddr;
  logic [ADDR_W-1:0]     e_raddr;
  logic                  i_last;
  logic                  j_last;
  logic                  out_take;
  logic [PROB_BITS-1:0]  emit_val;
  logic [PROB_BITS-1:0]  alpha_val;
  logic [ACC_W-1:0]      mul_a;
  logic [U_W-1:0]        mul_p;
  logic [S_W:0]          r_sh;
  logic [S_W:0]          s_ext;
  logic                  zero;
  logic [S_W-1:0]        sum_sh;
  logic [23:0]           sum_sat;
  logic [PROB_BITS-1:0]  alpha_w;

  assign pop         = cmd_valid_i && (state_q == ST_IDLE);
  assign cmd_ready_o = state_q == ST_IDLE;
  assign t_we        = pop && (cmd_i.kind == CMD_LOAD_T);
  assign e_we        = pop && (cmd_i.kind == CMD_LOAD_E);
  assign i_we        = pop && (cmd_i.kind == CMD_LOAD_I);
  assign t_raddr     = ADDR_W'(j_q) * ADDR_W'(STATES) + ADDR_W'(i_q);
  assign e_raddr     = ADDR_W'(i_q) * ADDR_W'(SYMBOLS) + ADDR_W'(sym_q);
  assign i_last      = i_q == IDX_W'(STATES - 1);
  assign j_last      = j_q == IDX_W'(STATES - 1);
  assign out_take    = (state_q == ST_OUT) && (!out_vld_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (t_we) trans_mem[cmd_i.addr] <= cmd_i.prob;
    trans_rd_q <= trans_mem[t_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (e_we) emit_mem[cmd_i.addr] <= cmd_i.prob;
    emit_rd_q <= emit_mem[e_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (i_we) init_mem[IDX_W'(cmd_i.addr)] <= cmd_i.prob;
    init_rd_q <= init_mem[i_q];
  end

  always_ff @(posedge clk_i) begin
    if (out_take) alpha_mem[i_q] <= alpha_w;
    alpha_rd_q <= alpha_mem[j_q];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_STORE) u_mem[i_q] <= u_q;
    u_rd_q <= u_mem[i_q];
  end

  // Datapath terms: emission gate, product operands, divider compare.
  assign emit_val  = sym_ok_q ? emit_rd_q : '0;
  assign alpha_val = alpha_vr_q ? alpha_rd_q : '0;
  assign mul_a     = start_q ? ACC_W'(init_rd_q) : acc_q;
  assign mul_p     = U_W'(mul_a) * U_W'(emit_val);
  assign r_sh      = {r_q, 1'b0};
  assign s_ext     = {1'b0, s_q};
  assign zero      = s_q == '0;
  assign sum_sh    = s_q >> SUM_SHIFT;
  assign sum_sat   = (sum_sh > S_W'(24'hFFFFFF)) ? 24'hFFFFFF : 24'(sum_sh);
  assign alpha_w   = zero ? '0 : (q_q[PROB_BITS] ? '1 : q_q[PROB_BITS-1:0]);

  // Sequencer and arithmetic registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      sym_q       <= '0;
      sym_ok_q    <= 1'b0;
      start_q     <= 1'b0;
      alpha_vld_q <= '0;
      alpha_vr_q  <= 1'b0;
      s1_vld_q    <= 1'b0;
      s1_last_q   <= 1'b0;
      s2_vld_q    <= 1'b0;
      s2_last_q   <= 1'b0;
      prod_q      <= '0;
      acc_q       <= '0;
      u_q         <= '0;
      s_q         <= '0;
      r_q         <= '0;
      q_q         <= '0;
      out_vld_q   <= 1'b0;
      out_idx_q   <= '0;
      out_alpha_q <= '0;
      out_sum_q   <= '0;
      out_zero_q  <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      // Multiply-accumulate pipeline behind the read stage.
      alpha_vr_q <= alpha_vld_q[j_q];
      s1_vld_q   <= state_q == ST_ISSUE;
      s1_last_q  <= start_q || j_last;
      s2_vld_q   <= s1_vld_q;
      s2_last_q  <= s1_last_q;
      prod_q     <= (2*PROB_BITS)'(alpha_val) * (2*PROB_BITS)'(trans_rd_q);
      if (s2_vld_q && !start_q) acc_q <= acc_q + ACC_W'(prod_q);

      if (out_vld_q && out_ready_i) out_vld_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (pop && cmd_i.kind == CMD_OBSERVE) begin
            sym_q    <= cmd_i.sym;
            sym_ok_q <= cmd_i.sym_ok;
            start_q  <= cmd_i.start;
            i_q      <= '0;
            j_q      <= '0;
            acc_q    <= '0;
            s_q      <= '0;
            state_q  <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (start_q || j_last) begin
            state_q <= ST_WAIT;
          end else begin
            j_q <= j_q + IDX_W'(1);
          end
        end
        ST_WAIT: begin
          if (s2_vld_q && s2_last_q) state_q <= ST_UMUL;
        end
        ST_UMUL: begin
          u_q     <= start_q ? (mul_p << PROB_BITS) : mul_p;
          state_q <= ST_STORE;
        end
        ST_STORE: begin
          s_q <= s_q + S_W'(u_q);
          j_q <= '0;
          acc_q <= '0;
          if (i_last) begin
            i_q     <= '0;
            state_q <= ST_DRD;
          end else begin
            i_q     <= i_q + IDX_W'(1);
            state_q <= ST_ISSUE;
          end
        end
        ST_DRD: begin
          state_q <= ST_DINIT;
        end
        ST_DINIT: begin
          // Integer bit of the quotient; u never exceeds the sum.
          if (S_W'(u_rd_q) >= s_q) begin
            r_q <= S_W'(u_rd_q) - s_q;
            q_q <= (PROB_BITS+1)'(1);
          end else begin
            r_q <= S_W'(u_rd_q);
            q_q <= '0;
          end
          k_q     <= '0;
          state_q <= ST_DSTEP;
        end
        ST_DSTEP: begin
          // One restoring division step per cycle.
          if (r_sh >= s_ext) begin
            r_q <= S_W'(r_sh - s_ext);
            q_q <= {q_q[PROB_BITS-1:0], 1'b1};
          end else begin
            r_q <= S_W'(r_sh);
            q_q <= {q_q[PROB_BITS-1:0], 1'b0};
          end
          if (k_q == K_W'(PROB_BITS - 1)) state_q <= ST_OUT;
          else k_q <= k_q + K_W'(1);
        end
        ST_OUT: begin
          if (out_take) begin
            out_vld_q      <= 1'b1;
            out_idx_q      <= 6'(i_q);
            out_alpha_q    <= 16'(alpha_w);
            out_sum_q      <= sum_sat;
            out_zero_q     <= zero;
            out_last_q     <= i_last;
            alpha_vld_q[i_q] <= 1'b1;
            if (i_last) begin
              i_q     <= '0;
              state_q <= ST_IDLE;
            end else begin
              i_q     <= i_q + IDX_W'(1);
              state_q <= ST_DRD;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_vld_q;
  assign state_index_o = out_idx_q;
  assign alpha_value_o = out_alpha_q;
  assign scale_sum_o   = out_sum_q;
  assign zero_sum_o    = out_zero_q;
  assign last_o        = out_last_q;

endmodule

>>> rtl/hsf_checker.sv
module hsf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  opcode_i,
  input logic [5:0]  row_index_i,
  input logic [7:0]  col_index_i,
  input logic [15:0] prob_value_i,
  input logic [7:0]  symbol_i,
  input logic        seq_start_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [5:0]  state_index_o,
  input logic [15:0] alpha_value_o,
  input logic [23:0] scale_sum_o,
  input logic        zero_sum_o,
  input logic        last_o
);
  import hsf_pkg::*;

  logic [5:0] exp_idx_q;

  // Track the state index the next result item must carry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      exp_idx_q <= last_o ? 6'd0 : exp_idx_q + 6'd1;
    end
  end

  // A waiting input item holds until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(opcode_i)
      && $stable(row_index_i) && $stable(col_index_i) && $stable(prob_value_i)
      && $stable(symbol_i) && $stable(seq_start_i))
    else $error("waiting input item changed");

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(alpha_value_o)
      && $stable(state_index_o) && $stable(scale_sum_o))
    else $error("stalled result item changed");

  // Result items come in state order.
  a_idx_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_index_o == exp_idx_q)
    else $error("result item out of state order");

  // The last flag marks exactly the final state.
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> last_o == (state_index_o == 6'(STATES - 1)))
    else $error("last flag does not match final state");

  // A zero sum forces zero alpha and zero reported sum.
  a_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_sum_o |-> alpha_value_o == 16'd0 && scale_sum_o == 24'd0)
    else $error("zero sum with nonzero alpha or sum");

endmodule

bind hmm_scaled_forward hsf_checker u_hsf_checker (.*);
